@@ sv/orq_pkg.sv @@
// Package with the shared types and codes of the ordered request queue.
`default_nettype none
package orq_pkg;

    localparam int DEF_CAPACITY = 16;

    typedef enum logic [2:0] {
        K_PUSH_WAIT = 3'd0,
        K_PUSH_WORK = 3'd1,
        K_POP_FRONT = 3'd2,
        K_POP_BACK  = 3'd3,
        K_RM_VALUE  = 3'd4,
        K_RM_POS    = 3'd5,
        K_CLEAR     = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_RANGE  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD,
        S_CHK,
        S_SH_CHK,
        S_SH_WR,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        SEL_FRONT,
        SEL_BACK,
        SEL_POS
    } t_idx_sel;

    typedef struct packed {
        logic [15:0] value;
        logic [31:0] arrival;
        logic [31:0] delay;
        logic [7:0]  handler;
    } t_entry;

    typedef struct packed {
        logic     load;
        logic     push;
        logic     clear;
        logic     set_idx;
        t_idx_sel idx_sel;
        logic     inc_idx;
        logic     rd_next;
        logic     take;
        logic     shift_wr;
        logic     dec_count;
        logic     set_status;
        t_status  status_val;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       empty;
        logic       full;
        logic       pos_bad;
        logic       last;
        logic       more;
        logic       match;
        logic       out_free;
    } t_stat;

endpackage
`default_nettype wire

@@ sv/orq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module orq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ sv/orq_ctrl.sv @@
// Controller state machine that sequences each queue operation.
`default_nettype none
module orq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire orq_pkg::t_stat i_stat,
    output orq_pkg::t_cmd      o_cmd
);
    import orq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.idx_sel    = SEL_FRONT;
        o_cmd.status_val = ST_OK;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (i_stat.kind)
                    K_PUSH_WAIT, K_PUSH_WORK: begin
                        if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status_val = ST_FULL;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                    K_POP_FRONT, K_POP_BACK, K_RM_VALUE, K_RM_POS: begin
                        if (i_stat.kind == K_RM_POS && i_stat.pos_bad) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status_val = ST_RANGE;
                        end else if (i_stat.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status_val = ST_EMPTY;
                        end else begin
                            o_cmd.set_idx = 1'b1;
                            if (i_stat.kind == K_POP_BACK) begin
                                o_cmd.idx_sel = SEL_BACK;
                            end else if (i_stat.kind == K_RM_POS) begin
                                o_cmd.idx_sel = SEL_POS;
                            end
                            n_state = S_RD;
                        end
                    end
                    K_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_stat.kind == K_RM_VALUE && !i_stat.match) begin
                    if (i_stat.last) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status_val = ST_EMPTY;
                        n_state          = S_DONE;
                    end else begin
                        o_cmd.inc_idx = 1'b1;
                        n_state       = S_RD;
                    end
                end else begin
                    o_cmd.take = 1'b1;
                    n_state    = S_SH_CHK;
                end
            end
            S_SH_CHK: begin
                o_cmd.rd_next = 1'b1;
                if (i_stat.more) begin
                    n_state = S_SH_WR;
                end else begin
                    o_cmd.dec_count = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_SH_WR: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.inc_idx  = 1'b1;
                n_state        = S_SH_CHK;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/orq_dp.sv @@
// Datapath with the entry memory, count, index and result registers.
`default_nettype none
module orq_dp #(
    parameter int CAPACITY = orq_pkg::DEF_CAPACITY
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire orq_pkg::t_cmd i_cmd,
    output orq_pkg::t_stat     o_stat,
    input  wire logic [2:0]    i_kind,
    input  wire logic [15:0]   i_entry_value,
    input  wire logic [31:0]   i_arrival_time,
    input  wire logic [31:0]   i_now_time,
    input  wire logic [7:0]    i_handler_id,
    input  wire logic [3:0]    i_position,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [1:0]         o_status,
    output logic [15:0]        o_out_value,
    output logic [31:0]        o_out_arrival,
    output logic [31:0]        o_out_delay,
    output logic [7:0]         o_out_handler,
    output logic [4:0]         o_queue_count
);
    import orq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [2:0]    r_kind;
    logic [15:0]   r_val;
    logic [31:0]   r_arr;
    logic [31:0]   r_now;
    logic [7:0]    r_hid;
    logic [3:0]    r_pos;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_idx;
    t_entry        r_rem;
    t_status       r_status;
    logic          r_ovalid;
    t_entry        r_o_entry;
    t_status       r_o_status;
    logic [CW-1:0] r_o_count;

    logic [CW-1:0] idx_p1;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    t_entry        wdata;
    t_entry        rdata;
    t_entry        new_entry;
    logic          we;

    assign idx_p1 = CW'(r_idx) + CW'(1);
    assign raddr  = i_cmd.rd_next ? AW'(idx_p1) : r_idx;

    always_comb begin
        new_entry.value   = r_val;
        new_entry.arrival = r_arr;
        if (r_kind == K_PUSH_WORK) begin
            new_entry.delay   = r_now - r_arr;
            new_entry.handler = r_hid;
        end else begin
            new_entry.delay   = '0;
            new_entry.handler = '0;
        end
    end

    assign we    = i_cmd.push || i_cmd.shift_wr;
    assign waddr = i_cmd.push ? AW'(r_count) : r_idx;
    assign wdata = i_cmd.push ? new_entry : rdata;

    orq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_val    <= i_entry_value;
            r_arr    <= i_arrival_time;
            r_now    <= i_now_time;
            r_hid    <= i_handler_id;
            r_pos    <= i_position;
            r_rem    <= '0;
            r_status <= ST_OK;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_val;
        end
        if (i_cmd.take) begin
            r_rem <= rdata;
        end
        if (i_cmd.set_idx) begin
            case (i_cmd.idx_sel)
                SEL_BACK: r_idx <= AW'(r_count - CW'(1));
                SEL_POS:  r_idx <= AW'(32'(r_pos));
                default:  r_idx <= '0;
            endcase
        end else if (i_cmd.inc_idx) begin
            r_idx <= AW'(idx_p1);
        end
        if (i_cmd.emit) begin
            r_o_entry  <= r_rem;
            r_o_status <= r_status;
            r_o_count  <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stat.kind     = r_kind;
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (32'(r_count) == CAPACITY);
    assign o_stat.pos_bad  = (32'(r_pos) >= 32'(r_count));
    assign o_stat.last     = (idx_p1 == r_count);
    assign o_stat.more     = (idx_p1 < r_count);
    assign o_stat.match    = (rdata.value == r_val);
    assign o_stat.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_o_status;
    assign o_out_value   = r_o_entry.value;
    assign o_out_arrival = r_o_entry.arrival;
    assign o_out_delay   = r_o_entry.delay;
    assign o_out_handler = r_o_entry.handler;
    assign o_queue_count = 5'(r_o_count);

endmodule
`default_nettype wire

@@ sv/ordered_request_queue.sv @@
// Top level of the ordered request queue: controller, datapath and checks.
//
//  Channel  Direction  Handshake                  Payload
//  request  in         i_in_valid / o_in_ready    i_kind, i_entry_value, i_arrival_time,
//                                                 i_now_time, i_handler_id, i_position
//  result   out        o_out_valid / i_out_ready  o_status, o_out_value, o_out_arrival,
//                                                 o_out_delay, o_out_handler, o_queue_count
//
// One operation is in flight at a time; a request is taken only in the idle state.
// Push, clear and rejected operations go from the execute state to the done state.
// A removal passes the read and check states, again per entry scanned without a match,
// then the shift states per entry shifted: the entry memory has a single read port.
// The next request can be taken in the cycle in which the result appears.
// Reset empties the queue; entry contents are left as they are.
// A result held by a stalled output stops the next operation at its final step.
`default_nettype none
module ordered_request_queue #(
    parameter int CAPACITY = orq_pkg::DEF_CAPACITY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [15:0] i_entry_value,
    input  wire logic [31:0] i_arrival_time,
    input  wire logic [31:0] i_now_time,
    input  wire logic [7:0]  i_handler_id,
    input  wire logic [3:0]  i_position,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [15:0]      o_out_value,
    output logic [31:0]      o_out_arrival,
    output logic [31:0]      o_out_delay,
    output logic [7:0]       o_out_handler,
    output logic [4:0]       o_queue_count
);
    import orq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    orq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    orq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_kind         (i_kind),
        .i_entry_value  (i_entry_value),
        .i_arrival_time (i_arrival_time),
        .i_now_time     (i_now_time),
        .i_handler_id   (i_handler_id),
        .i_position     (i_position),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_out_value    (o_out_value),
        .o_out_arrival  (o_out_arrival),
        .o_out_delay    (o_out_delay),
        .o_out_handler  (o_out_handler),
        .o_queue_count  (o_queue_count)
    );

    a_push_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.push && (cmd.shift_wr || cmd.dec_count || cmd.clear)))
        else $error("push collides with another queue update");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_queue_count == 5'(CAPACITY)))
        else $error("full status with a queue that is not full");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
            (o_out_value == '0 && o_out_arrival == '0 && o_out_delay == '0
             && o_out_handler == '0))
        else $error("failed operation reports a removed entry");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("result written over one not yet taken");

endmodule
`default_nettype wire

@@ tb/ordered_request_queue_tb.sv @@
// Testbench for the ordered request queue: random and directed operations checked against a queue model.
`timescale 1ns / 1ps
`default_nettype none
module ordered_request_queue_tb;
    import orq_pkg::*;

    localparam int CAP = 16;
    localparam int RANDOM_OPS = 1850;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
        logic [31:0] arrival;
        logic [31:0] now;
        logic [7:0]  handler;
        logic [3:0]  position;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] value;
        logic [31:0] arrival;
        logic [31:0] delay;
        logic [7:0]  handler;
        logic [4:0]  count;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [2:0] i_kind = '0;
    logic [15:0] i_entry_value = '0;
    logic [31:0] i_arrival_time = '0;
    logic [31:0] i_now_time = '0;
    logic [7:0] i_handler_id = '0;
    logic [3:0] i_position = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [1:0] o_status;
    logic [15:0] o_out_value;
    logic [31:0] o_out_arrival;
    logic [31:0] o_out_delay;
    logic [7:0] o_out_handler;
    logic [4:0] o_queue_count;

    ordered_request_queue i_dut (.*);

    always #2 i_clk = ~i_clk;

    t_request pending_requests[$];
    t_outcome expected_outcomes[$];
    t_entry model_queue[$];
    int mismatch_count = 0;
    longint cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_phase = 0;
    bit stimulus_done = 1'b0;

    function automatic t_outcome apply_request(t_request r);
        t_outcome o;
        t_entry e;
        int idx;
        o = '0;
        idx = -1;
        case (r.kind)
            K_PUSH_WAIT, K_PUSH_WORK: begin
                if (model_queue.size() >= CAP) begin
                    o.status = ST_FULL;
                end else begin
                    e.value = r.value;
                    e.arrival = r.arrival;
                    e.delay = (r.kind == K_PUSH_WORK) ? r.now - r.arrival : 32'd0;
                    e.handler = (r.kind == K_PUSH_WORK) ? r.handler : 8'd0;
                    model_queue.push_back(e);
                end
            end
            K_POP_FRONT: if (model_queue.size() == 0) o.status = ST_EMPTY; else idx = 0;
            K_POP_BACK: begin
                if (model_queue.size() == 0) o.status = ST_EMPTY;
                else idx = model_queue.size() - 1;
            end
            K_RM_VALUE: begin
                for (int i = 0; i < model_queue.size(); i++) begin
                    if (idx < 0 && model_queue[i].value == r.value) idx = i;
                end
                if (idx < 0) o.status = ST_EMPTY;
            end
            K_RM_POS: begin
                if (r.position >= model_queue.size()) o.status = ST_RANGE;
                else idx = r.position;
            end
            K_CLEAR: model_queue.delete();
            default: ;
        endcase
        if (idx >= 0) begin
            o.value = model_queue[idx].value;
            o.arrival = model_queue[idx].arrival;
            o.delay = model_queue[idx].delay;
            o.handler = model_queue[idx].handler;
            model_queue.delete(idx);
        end
        o.count = 5'(model_queue.size());
        return o;
    endfunction

    function automatic t_request random_request(int depth_hint);
        t_request r;
        int pick;
        r.value = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
        r.arrival = $urandom;
        r.now = ($urandom_range(0, 1) == 0) ? $urandom : r.arrival + $urandom_range(0, 5000);
        r.handler = 8'($urandom);
        r.position = 4'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25 + depth_hint) r.kind = K_PUSH_WAIT;
        else if (pick < 50 + depth_hint) r.kind = K_PUSH_WORK;
        else if (pick < 60) r.kind = K_POP_FRONT;
        else if (pick < 70) r.kind = K_POP_BACK;
        else if (pick < 82) r.kind = K_RM_VALUE;
        else if (pick < 95) r.kind = K_RM_POS;
        else if (pick < 98) r.kind = K_CLEAR;
        else r.kind = 3'd7;
        return r;
    endfunction

    function automatic t_request make_request(logic [2:0] k, logic [15:0] v, logic [31:0] a,
                                              logic [31:0] n, logic [7:0] h, logic [3:0] p);
        t_request r;
        r.kind = k;
        r.value = v;
        r.arrival = a;
        r.now = n;
        r.handler = h;
        r.position = p;
        return r;
    endfunction

    initial begin
        int phase_bias;
        pending_requests.push_back(make_request(K_POP_FRONT, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(K_POP_BACK, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(K_RM_VALUE, 16'hFFFF, 0, 0, 0, 0));
        pending_requests.push_back(make_request(K_RM_POS, 0, 0, 0, 0, 4'hF));
        pending_requests.push_back(make_request(K_PUSH_WORK, 16'hFFFF, 32'hFFFF_FFFF, 32'd0,
                                                8'hFF, 4'hF));
        pending_requests.push_back(make_request(K_PUSH_WAIT, 16'h0000, 32'd0, 32'hFFFF_FFFF,
                                                8'hFF, 0));
        for (int i = 0; i < 15; i++)
            pending_requests.push_back(make_request(K_PUSH_WORK, 16'(i), $urandom, $urandom,
                                                    8'(i), 0));
        pending_requests.push_back(make_request(K_RM_POS, 0, 0, 0, 0, 4'hF));
        pending_requests.push_back(make_request(K_RM_VALUE, 16'd5, 0, 0, 0, 0));
        pending_requests.push_back(make_request(3'd7, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(K_CLEAR, 0, 0, 0, 0, 0));
        for (int i = 0; i < RANDOM_OPS; i++) begin
            phase_bias = ((i / 200) % 2 == 0) ? 12 : -10;
            pending_requests.push_back(random_request(phase_bias));
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == 1) i_rst_n <= 1'b1;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_outcomes.push_back(apply_request(pending_requests.pop_front()));
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    t_request nxt;
                    nxt = pending_requests[0];
                    i_in_valid <= 1'b1;
                    i_kind <= nxt.kind;
                    i_entry_value <= nxt.value;
                    i_arrival_time <= nxt.arrival;
                    i_now_time <= nxt.now;
                    i_handler_id <= nxt.handler;
                    i_position <= nxt.position;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_outcome want;
        stall_phase <= (stall_phase + 1) % 97;
        i_out_ready <= (stall_phase < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_outcomes.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                $display("%0t: result with none expected, actual %h", $time,
                         {o_status, o_out_value, o_out_arrival, o_out_delay, o_out_handler,
                          o_queue_count});
            end else begin
                want = expected_outcomes.pop_front();
                if (want !== {o_status, o_out_value, o_out_arrival, o_out_delay,
                              o_out_handler, o_queue_count}) begin
                    mismatch_count <= mismatch_count + 1;
                    $display("%0t: expected st=%0d val=%h arr=%h dly=%h hid=%h cnt=%0d", $time,
                             want.status, want.value, want.arrival, want.delay, want.handler,
                             want.count);
                    $display("%0t: actual   st=%0d val=%h arr=%h dly=%h hid=%h cnt=%0d", $time,
                             o_status, o_out_value, o_out_arrival, o_out_delay, o_out_handler,
                             o_queue_count);
                end
            end
        end
    end

    initial begin
        wait (stimulus_done && pending_requests.size() == 0 && !i_in_valid &&
              expected_outcomes.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end
endmodule
`default_nettype wire
